// ----- sv/rab_pkg.sv -----
package rab_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = 4095;
    localparam int PCT_W      = 7;
    localparam int PCT_SPAN   = 100;
    localparam int FS_RESET   = 3300;
    localparam int PROD_W     = 19;
    localparam int DIVS_W     = 12;
    localparam int WINDOW_DEF = 10;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_MUL,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_OUT
    } t_state;

endpackage

// ----- sv/rolling_average_brightness_top.sv -----
// Channel  Direction  Width  Contents
// s        in         16     sample_mv [11:0]
// m        out        24     average_mv [11:0], brightness_pct [18:12]
// cfg      in         12     full_scale_mv [11:0]
//
// One transaction in gives one transaction out; a new sample is accepted only once
// the last result is in the output register. DW = max(sum width, 19): the shared
// serial divider runs twice (mean, then percent) at one quotient bit per cycle. DW
// is 19 for WINDOW up to 128. Reset clears the sample cells, sum, fill count and
// control at once. The output register frees the input side while a result
// waits; the next result is held back until the output is taken.
module rolling_average_brightness_top #(
    parameter int WINDOW = rab_pkg::WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rab_pkg::S_TDATA_W-1:0]  i_s_tdata,   // sample_mv
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rab_pkg::M_TDATA_W-1:0]  o_m_tdata,   // average_mv, brightness_pct
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rab_pkg::SAMPLE_W-1:0]   i_cfg_data   // full_scale_mv
);

    localparam int SUM_W = $clog2(WINDOW * rab_pkg::SAMPLE_MAX + 1);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int DW    = (SUM_W > rab_pkg::PROD_W) ? SUM_W : rab_pkg::PROD_W;
    localparam int PAD_W = rab_pkg::M_TDATA_W - rab_pkg::SAMPLE_W - rab_pkg::PCT_W;

    rab_pkg::t_state r_state, n_state;

    logic [rab_pkg::SAMPLE_W-1:0]  w_tap [WINDOW];
    logic [rab_pkg::SAMPLE_W-1:0]  w_sample;
    logic                          w_shift;
    logic [SUM_W-1:0]              r_sum;
    logic [CNT_W-1:0]              r_fill;
    logic [rab_pkg::SAMPLE_W-1:0]  r_fs;
    logic [rab_pkg::SAMPLE_W-1:0]  r_avg;
    logic [rab_pkg::PROD_W-1:0]    r_prod;
    logic                          r_out_valid;
    logic [rab_pkg::M_TDATA_W-1:0] r_out_data;
    logic                          w_out_free;
    logic                          w_div_start;
    logic [DW-1:0]                 w_dividend;
    logic [rab_pkg::DIVS_W-1:0]    w_divisor;
    logic                          w_div_done;
    logic [DW-1:0]                 w_quo;
    logic [rab_pkg::PCT_W-1:0]     w_pct;

    assign w_sample   = i_s_tdata[rab_pkg::SAMPLE_W-1:0];
    assign o_s_tready = (r_state == rab_pkg::ST_IDLE);
    assign w_shift    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    // sample line: newest in cell 0, oldest leaves the last cell
    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            if (g == 0) begin : g_head
                rab_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_d     (w_sample),
                    .o_q     (w_tap[g])
                );
            end else begin : g_body
                rab_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_d     (w_tap[g-1]),
                    .o_q     (w_tap[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
        end else if (w_shift) begin
            r_sum <= r_sum - SUM_W'(w_tap[WINDOW-1]) + SUM_W'(w_sample);
            if (r_fill != CNT_W'(WINDOW)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= rab_pkg::SAMPLE_W'(rab_pkg::FS_RESET);
        end else if (i_cfg_valid) begin
            r_fs <= i_cfg_data;
        end
    end

    rab_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rab_pkg::ST_IDLE:     if (w_shift) n_state = rab_pkg::ST_AVG_GO;
            rab_pkg::ST_AVG_GO:   n_state = rab_pkg::ST_AVG_WAIT;
            rab_pkg::ST_AVG_WAIT: if (w_div_done) n_state = rab_pkg::ST_MUL;
            rab_pkg::ST_MUL:      n_state = rab_pkg::ST_PCT_GO;
            rab_pkg::ST_PCT_GO:   n_state = rab_pkg::ST_PCT_WAIT;
            rab_pkg::ST_PCT_WAIT: if (w_div_done) n_state = rab_pkg::ST_OUT;
            rab_pkg::ST_OUT:      if (w_out_free) n_state = rab_pkg::ST_IDLE;
            default:              n_state = rab_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = DW'(r_sum);
        w_divisor   = rab_pkg::DIVS_W'(r_fill);
        unique case (r_state)
            rab_pkg::ST_AVG_GO: begin
                w_div_start = 1'b1;
            end
            rab_pkg::ST_PCT_GO: begin
                w_div_start = 1'b1;
                w_dividend  = DW'(r_prod);
                w_divisor   = r_fs;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rab_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // zero full scale divides to all ones and so saturates to 0 as well
    assign w_pct = (w_quo >= DW'(rab_pkg::PCT_SPAN)) ? '0
                 : rab_pkg::PCT_W'(rab_pkg::PCT_SPAN) - w_quo[rab_pkg::PCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == rab_pkg::ST_AVG_WAIT && w_div_done) begin
            r_avg <= w_quo[rab_pkg::SAMPLE_W-1:0];
        end
        if (r_state == rab_pkg::ST_MUL) begin
            r_prod <= rab_pkg::PROD_W'(r_avg) * rab_pkg::PROD_W'(rab_pkg::PCT_SPAN);
        end
        if (r_state == rab_pkg::ST_OUT && w_out_free) begin
            r_out_data <= {PAD_W'(0), w_pct, r_avg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rab_pkg::ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |=> r_state == rab_pkg::ST_AVG_GO)
        else $error("accepted sample did not start the mean");

    a_out_from_fsm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == rab_pkg::ST_OUT)
        else $error("result raised outside output state");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[rab_pkg::SAMPLE_W +: rab_pkg::PCT_W]
                        <= rab_pkg::PCT_W'(rab_pkg::PCT_SPAN))
        else $error("brightness percent above span");

endmodule

// ----- sv/rab_cell.sv -----
module rab_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [rab_pkg::SAMPLE_W-1:0]  i_d,
    output logic [rab_pkg::SAMPLE_W-1:0]  o_q
);

    logic [rab_pkg::SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- sv/rab_div.sv -----
module rab_div #(
    parameter int DW = rab_pkg::PROD_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_dividend,
    input  logic [rab_pkg::DIVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [DW-1:0]               o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]               r_quo;
    logic [rab_pkg::DIVS_W-1:0]  r_rem;
    logic [rab_pkg::DIVS_W-1:0]  r_div;
    logic [CW-1:0]               r_cnt;
    logic                        r_done;
    logic [rab_pkg::DIVS_W:0]    w_trial;
    logic [rab_pkg::DIVS_W:0]    w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[rab_pkg::DIVS_W-1:0] : w_trial[rab_pkg::DIVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
